@@ rtl/bbd_pkg.sv @@
// Shared types, constants and helpers for the bilinear Bayer demosaic block.
// No dependencies; imported by bbd_ram and bayer_bilinear_demosaic_core.
`default_nettype none

package bbd_pkg;

    // Default geometry limits
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    // Pixel and field widths
    localparam int PIX_W   = 8;
    localparam int POS_W   = 11;
    localparam int SIZE_W  = 12;
    localparam int CFG_W   = 12;
    localparam int IDX_W   = 2;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 48;

    // Register reset values
    localparam logic [SIZE_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 12'd480;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_PATTERN = 2'd0,
        REG_SWAP    = 2'd1,
        REG_WIDTH   = 2'd2,
        REG_HEIGHT  = 2'd3
    } t_reg_idx;

    // Interpolation choice for one channel
    typedef enum logic [2:0] {
        PICK_C = 3'd0,  // center sample
        PICK_X = 3'd1,  // cross average
        PICK_D = 3'd2,  // diagonal average
        PICK_H = 3'd3,  // horizontal average
        PICK_V = 3'd4   // vertical average
    } t_pick;

    // [pattern][row parity][column parity][channel R,G,B]
    localparam t_pick PICK_TABLE [4][2][2][3] = '{
        '{ '{ '{PICK_C, PICK_X, PICK_D}, '{PICK_H, PICK_C, PICK_V} },
           '{ '{PICK_V, PICK_C, PICK_H}, '{PICK_D, PICK_X, PICK_C} } },
        '{ '{ '{PICK_D, PICK_X, PICK_C}, '{PICK_V, PICK_C, PICK_H} },
           '{ '{PICK_C, PICK_X, PICK_D}, '{PICK_H, PICK_C, PICK_V} } },
        '{ '{ '{PICK_H, PICK_C, PICK_V}, '{PICK_C, PICK_X, PICK_D} },
           '{ '{PICK_D, PICK_X, PICK_C}, '{PICK_V, PICK_C, PICK_H} } },
        '{ '{ '{PICK_V, PICK_C, PICK_H}, '{PICK_D, PICK_X, PICK_C} },
           '{ '{PICK_H, PICK_C, PICK_V}, '{PICK_C, PICK_X, PICK_D} } }
    };

    // Limit a programmed frame size to [3, hi]
    function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] res;
        if (v < 32'd3) begin
            res = 32'd3;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bbd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// A read and a write to the same address at one edge return the old data.
`default_nettype none

module bbd_ram
    import bbd_pkg::*;
#(
    parameter int WIDTH = 2 * PIX_W,
    parameter int DEPTH = MAX_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/bayer_bilinear_demosaic_core.sv @@
// Bilinear Bayer demosaic core: line store RAM, 3x3 window, channel select.
// Depends on bbd_pkg and bbd_ram.
// An accepted pixel is registered in stage 1, then its result in the output register.
// One pixel per cycle while not back-pressured; line store: one read, one write port.
// Reset (synchronous, active low) clears counters, window, pipeline valids and
// loads the register defaults; line store contents stay undefined until written.
`default_nettype none

module bayer_bilinear_demosaic_core
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // configuration write port
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    // raw pixel stream
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,   // [7:0] raw_pixel
    input  wire logic [0:0]       s_axis_tuser,   // [0] start_of_frame
    // RGB stream
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic      [OUT_W-1:0] m_axis_tdata,   // red, green, blue, out_column, out_row
    output logic                  m_axis_tlast    // frame_done
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SWW = $clog2(MAX_WIDTH + 1);
    localparam int SWH = $clog2(MAX_HEIGHT + 1);
    localparam int LW  = 2 * PIX_W;

    // Configuration registers
    logic [1:0]        r_pattern;
    logic              r_swap;
    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_swap    <= 1'b0;
            r_width   <= WIDTH_RST;
            r_height  <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_PATTERN: r_pattern <= i_cfg_data[1:0];
                REG_SWAP:    r_swap    <= i_cfg_data[0];
                REG_WIDTH:   r_width   <= i_cfg_data[SIZE_W-1:0];
                REG_HEIGHT:  r_height  <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Frame size in use
    logic [SWW-1:0] w_eff;
    logic [SWH-1:0] h_eff;
    logic [31:0]    w_clamp;
    logic [31:0]    h_clamp;

    assign w_clamp = clamp_size(32'(r_width), 32'(MAX_WIDTH));
    assign h_clamp = clamp_size(32'(r_height), 32'(MAX_HEIGHT));
    assign w_eff   = w_clamp[SWW-1:0];
    assign h_eff   = h_clamp[SWH-1:0];

    // Pipeline advance: output register free or being emptied
    logic adv;
    logic accept;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    // Position of the arriving pixel
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic          sof;

    assign sof = s_axis_tuser[0];

    always_comb begin
        cur_col = r_col;
        cur_row = r_row;
        if (sof || (SWW'(r_col) >= w_eff)) begin
            cur_col = '0;
        end
        if (sof || (SWH'(r_row) >= h_eff)) begin
            cur_row = '0;
        end
        // step to the next raster position
        if (SWW'(cur_col) + SWW'(1) >= w_eff) begin
            n_col = '0;
            n_row = (SWH'(cur_row) + SWH'(1) >= h_eff) ? '0 : cur_row + RW'(1);
        end else begin
            n_col = cur_col + CW'(1);
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage 1: pixel waiting for its line store read
    logic             r_v1;
    logic [PIX_W-1:0] r_px1;
    logic [CW-1:0]    r_c1;
    logic [RW-1:0]    r_r1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px1 <= s_axis_tdata[PIX_W-1:0];
            r_c1  <= cur_col;
            r_r1  <= cur_row;
        end
    end

    // Line store: {row two above, row just above} per column
    logic [LW-1:0]    ram_q;
    logic [LW-1:0]    line_pair;
    logic [LW-1:0]    line_wdata;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic             wr_en;

    // Forward the pair written at the same edge as the read of the same column
    logic          r_fwd;
    logic [LW-1:0] r_fwd_data;

    assign line_pair  = r_fwd ? r_fwd_data : ram_q;
    assign top        = line_pair[LW-1:PIX_W];
    assign mid        = line_pair[PIX_W-1:0];
    assign line_wdata = {mid, r_px1};
    assign wr_en      = adv && r_v1;

    bbd_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_c1),
        .i_wdata (line_wdata),
        .i_re    (accept),
        .i_raddr (cur_col),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (adv) begin
            r_fwd <= accept && r_v1 && (cur_col == r_c1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fwd_data <= line_wdata;
        end
    end

    // 3x3 window shift
    logic [PIX_W-1:0] r_win [9];
    logic [PIX_W-1:0] n_win [9];

    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = top;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = mid;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_px1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (wr_en) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

    // Neighborhood averages
    logic [PIX_W+1:0] sum_x;
    logic [PIX_W+1:0] sum_d;
    logic [PIX_W:0]   sum_h;
    logic [PIX_W:0]   sum_v;
    logic [PIX_W-1:0] val_c;
    logic [PIX_W-1:0] val_x;
    logic [PIX_W-1:0] val_d;
    logic [PIX_W-1:0] val_h;
    logic [PIX_W-1:0] val_v;

    assign sum_x = (PIX_W+2)'(n_win[3]) + (PIX_W+2)'(n_win[5])
                 + (PIX_W+2)'(n_win[1]) + (PIX_W+2)'(n_win[7]);
    assign sum_d = (PIX_W+2)'(n_win[0]) + (PIX_W+2)'(n_win[2])
                 + (PIX_W+2)'(n_win[6]) + (PIX_W+2)'(n_win[8]);
    assign sum_h = (PIX_W+1)'(n_win[3]) + (PIX_W+1)'(n_win[5]);
    assign sum_v = (PIX_W+1)'(n_win[1]) + (PIX_W+1)'(n_win[7]);
    assign val_c = n_win[4];
    assign val_x = sum_x[PIX_W+1:2];
    assign val_d = sum_d[PIX_W+1:2];
    assign val_h = sum_h[PIX_W:1];
    assign val_v = sum_v[PIX_W:1];

    function automatic logic [PIX_W-1:0] pick_value(
        input t_pick            sel,
        input logic [PIX_W-1:0] vc,
        input logic [PIX_W-1:0] vx,
        input logic [PIX_W-1:0] vd,
        input logic [PIX_W-1:0] vh,
        input logic [PIX_W-1:0] vv
    );
        logic [PIX_W-1:0] res;
        unique case (sel)
            PICK_C:  res = vc;
            PICK_X:  res = vx;
            PICK_D:  res = vd;
            PICK_H:  res = vh;
            PICK_V:  res = vv;
            default: res = vc;
        endcase
        return res;
    endfunction

    // Channel selection for the window center
    logic [CW-1:0]    oc;
    logic [RW-1:0]    orow;
    logic             interior;
    logic             last_px;
    logic [PIX_W-1:0] ch_r;
    logic [PIX_W-1:0] ch_g;
    logic [PIX_W-1:0] ch_b;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] blue;

    assign oc       = r_c1 - CW'(1);
    assign orow     = r_r1 - RW'(1);
    assign interior = (r_c1 >= CW'(2)) && (r_r1 >= RW'(2));
    assign last_px  = (SWW'(r_c1) == w_eff - SWW'(1)) && (SWH'(r_r1) == h_eff - SWH'(1));

    assign ch_r = pick_value(PICK_TABLE[r_pattern][orow[0]][oc[0]][0],
                             val_c, val_x, val_d, val_h, val_v);
    assign ch_g = pick_value(PICK_TABLE[r_pattern][orow[0]][oc[0]][1],
                             val_c, val_x, val_d, val_h, val_v);
    assign ch_b = pick_value(PICK_TABLE[r_pattern][orow[0]][oc[0]][2],
                             val_c, val_x, val_d, val_h, val_v);
    assign red  = r_swap ? ch_b : ch_r;
    assign blue = r_swap ? ch_r : ch_b;

    // Output register
    logic             r_m_valid;
    logic [OUT_W-1:0] r_m_data;
    logic             r_m_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (adv) begin
            r_m_valid <= r_v1 && interior;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_m_data <= {2'b00, POS_W'(orow), POS_W'(oc), blue, ch_g, red};
            r_m_last <= last_px;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

`ifndef SYNTH
    // Forwarded line data only ever belongs to a pixel in stage 1
    a_fwd_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_v1)
        else $error("line forward flag set without a stage-1 pixel");

    // Column counter never reaches the line store depth
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < MAX_WIDTH)
        else $error("column counter out of range");

    // A result never comes from a border position
    a_no_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[34:24] != '0) && (m_axis_tdata[45:35] != '0))
        else $error("border pixel produced a result");
`endif

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking bench for bayer_bilinear_demosaic_core: streams raw Bayer frames
// and checks every RGB transaction against an in-bench bilinear interpolator.
// Depends on bbd_pkg and the core RTL only.
`timescale 1ns / 100ps

module testbench;
    import bbd_pkg::*;

    localparam int SETTLE_CYCLES = 8;       // settle margin after the pipeline drains
    localparam int CYCLE_LIMIT   = 500000;

    typedef struct packed {
        logic       sof;
        logic [7:0] px;
    } t_raw_item;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [10:0] col;
        logic [10:0] row;
        logic        done;
    } t_rgb_result;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx     = '0;
    logic [CFG_W-1:0] i_cfg_data    = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;   // [7:0] raw_pixel
    logic [0:0]       s_axis_tuser  = '0;   // [0] start_of_frame
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;         // red, green, blue, out_column, out_row
    logic             m_axis_tlast;         // frame_done

    bayer_bilinear_demosaic_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus and scoreboard storage
    t_raw_item   raw_pending [$];
    t_rgb_result rgb_expected [$];
    t_raw_item   next_raw;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        feed_hold = 1'b0;
    logic        pix_taken = 1'b0;
    logic        nothing_owed = 1'b1;
    int          err_count = 0;
    int          cycle_cnt = 0;
    logic [11:0] plan_width = WIDTH_RST;

    // Interpolator state: register shadows, line stores, window, position
    logic [1:0]  cfg_pattern;
    logic        cfg_swap;
    logic [11:0] cfg_width;
    logic [11:0] cfg_height;
    logic [7:0]  line_up2 [MAX_WIDTH_DEF];
    logic [7:0]  line_up1 [MAX_WIDTH_DEF];
    logic [7:0]  win [9];
    int unsigned col_pos;
    int unsigned row_pos;

    function automatic int unsigned eff_size(input logic [11:0] v, input int unsigned hi);
        if (v < 12'd3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    // Advance the interpolator by one raw sample; queue the RGB pixel if interior
    task automatic demosaic_predict(input logic [7:0] px, input logic sof);
        int unsigned w, h, c, r;
        logic [7:0]  up2, up1, red_v, grn_v, blu_v, tmp;
        logic [9:0]  sum_cross, sum_diag;
        logic [8:0]  sum_h, sum_v;
        logic [7:0]  vals [5];
        logic [10:0] ocol, orow;
        t_rgb_result res;
        w = eff_size(cfg_width, MAX_WIDTH_DEF);
        h = eff_size(cfg_height, MAX_HEIGHT_DEF);
        if (sof) begin
            col_pos = 0;
            row_pos = 0;
        end
        // shrunk geometry restarts the counter
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        r = row_pos;

        up2 = line_up2[c];
        up1 = line_up1[c];
        line_up2[c] = up1;
        line_up1[c] = px;

        win[0] = win[1]; win[1] = win[2]; win[2] = up2;
        win[3] = win[4]; win[4] = win[5]; win[5] = up1;
        win[6] = win[7]; win[7] = win[8]; win[8] = px;

        if (r >= 2 && c >= 2) begin
            sum_cross = 10'(win[3]) + 10'(win[5]) + 10'(win[1]) + 10'(win[7]);
            sum_diag  = 10'(win[0]) + 10'(win[2]) + 10'(win[6]) + 10'(win[8]);
            sum_h     = 9'(win[3]) + 9'(win[5]);
            sum_v     = 9'(win[1]) + 9'(win[7]);
            vals[PICK_C] = win[4];
            vals[PICK_X] = sum_cross[9:2];
            vals[PICK_D] = sum_diag[9:2];
            vals[PICK_H] = sum_h[8:1];
            vals[PICK_V] = sum_v[8:1];
            ocol = 11'(c - 1);
            orow = 11'(r - 1);
            // channel choice by layout and the parity of the output position
            red_v = vals[PICK_TABLE[cfg_pattern][orow[0]][ocol[0]][0]];
            grn_v = vals[PICK_TABLE[cfg_pattern][orow[0]][ocol[0]][1]];
            blu_v = vals[PICK_TABLE[cfg_pattern][orow[0]][ocol[0]][2]];
            if (cfg_swap) begin
                tmp   = red_v;
                red_v = blu_v;
                blu_v = tmp;
            end
            res.red   = red_v;
            res.green = grn_v;
            res.blue  = blu_v;
            res.col   = ocol;
            res.row   = orow;
            res.done  = (c == w - 1) && (r == h - 1);
            rgb_expected.push_back(res);
        end

        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input t_rgb_result at);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d (pixel col %0d row %0d)",
                                      name, got, want, at.col, at.row));
    endtask

    // Compare one RGB transaction against the oldest prediction
    task automatic check_rgb();
        t_rgb_result want;
        if (rgb_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected RGB transaction %h last %b",
                                      m_axis_tdata, m_axis_tlast));
            return;
        end
        want = rgb_expected.pop_front();
        check_field("red",        32'(m_axis_tdata[7:0]),   32'(want.red),   want);
        check_field("green",      32'(m_axis_tdata[15:8]),  32'(want.green), want);
        check_field("blue",       32'(m_axis_tdata[23:16]), 32'(want.blue),  want);
        check_field("out_column", 32'(m_axis_tdata[34:24]), 32'(want.col),   want);
        check_field("out_row",    32'(m_axis_tdata[45:35]), 32'(want.row),   want);
        check_field("frame_done", 32'(m_axis_tlast),        32'(want.done),  want);
    endtask

    // Monitor: register writes, accepted pixels and RGB transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_pattern = 2'd0;
            cfg_swap    = 1'b0;
            cfg_width   = WIDTH_RST;
            cfg_height  = HEIGHT_RST;
            col_pos     = 0;
            row_pos     = 0;
            for (int i = 0; i < 9; i++) win[i] = 8'd0;
            pix_taken    <= 1'b0;
            nothing_owed <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PATTERN: cfg_pattern = i_cfg_data[1:0];
                    REG_SWAP:    cfg_swap    = i_cfg_data[0];
                    REG_WIDTH:   cfg_width   = i_cfg_data;
                    default:     cfg_height  = i_cfg_data;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                demosaic_predict(s_axis_tdata, s_axis_tuser[0]);
            if (m_axis_tvalid && m_axis_tready)
                check_rgb();
            pix_taken    <= s_axis_tvalid && s_axis_tready;
            nothing_owed <= (rgb_expected.size() == 0);
        end
    end

    // Driver: present the next raw pixel, holding it until the transaction completes
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || pix_taken) begin
            if (raw_pending.size() != 0 && !feed_hold &&
                $urandom_range(99) >= send_idle_pct) begin
                next_raw = raw_pending.pop_front();
                s_axis_tdata  <= next_raw.px;
                s_axis_tuser  <= next_raw.sof;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_pixel(input logic [7:0] px, input logic sof);
        t_raw_item it;
        it.px  = px;
        it.sof = sof;
        raw_pending.push_back(it);
    endtask

    // Wait until no pixel is pending and every RGB transaction has arrived
    task automatic drain();
        do @(posedge i_clk);
        while (raw_pending.size() != 0 || s_axis_tvalid || !nothing_owed);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
    endtask

    // Program all registers with the block idle; flags a wider line
    task automatic reconfigure(input logic [11:0] pat, input logic [11:0] swp,
                               input logic [11:0] wd, input logic [11:0] ht,
                               output bit grew);
        drain();
        grew = eff_size(wd, MAX_WIDTH_DEF) > eff_size(plan_width, MAX_WIDTH_DEF);
        write_reg(REG_PATTERN, pat);
        write_reg(REG_SWAP, swp);
        write_reg(REG_WIDTH, wd);
        write_reg(REG_HEIGHT, ht);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        plan_width = wd;
        @(posedge i_clk);
    endtask

    // Mostly whole frames of random content, some truncated, stray frame starts
    task automatic queue_stream(input int unsigned n_items, input bit first_sof,
                                input logic [11:0] wd, input logic [11:0] ht);
        int unsigned len, sent, k;
        logic        sof;
        sent = 0;
        while (sent < n_items) begin
            len = eff_size(wd, MAX_WIDTH_DEF) * eff_size(ht, MAX_HEIGHT_DEF);
            if ($urandom_range(9) == 0) len = $urandom_range(len, 1);
            for (k = 0; k < len && sent < n_items; k++) begin
                if (k == 0) sof = (sent == 0) ? first_sof : ($urandom_range(4) != 0);
                else sof = 1'b0;
                if ($urandom_range(63) == 0) sof = 1'b1;
                queue_pixel(8'($urandom_range(255)), sof | first_sof & (sent == 0));
                sent++;
            end
        end
    endtask

    initial begin
        bit          grew;
        logic [11:0] pat, swp, wd, ht;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: smallest frame, extreme values, wrap without frame start
        reconfigure(12'd0, 12'd0, 12'd3, 12'd3, grew);
        for (int k = 0; k < 9; k++) queue_pixel((k % 2) ? 8'd0 : 8'd255, k == 0);
        for (int k = 0; k < 9; k++) queue_pixel(8'd255, 1'b0);
        // frame start in the middle of a frame
        queue_pixel(8'd17, 1'b0);
        for (int k = 0; k < 9; k++) queue_pixel((k % 3) ? 8'd255 : 8'd1, k == 0);

        // Sizes below the minimum clamp to 3
        reconfigure(12'hFFD, 12'hFFE, 12'd0, 12'd2, grew);
        for (int k = 0; k < 18; k++) queue_pixel(8'($urandom_range(255)), k == 0);

        // Line clamped from all ones to the widest size, first pixels of a row
        reconfigure(12'd3, 12'd1, 12'hFFF, 12'd3, grew);
        for (int k = 0; k < 64; k++) queue_pixel(8'($urandom_range(255)), k == 0);
        // Frame height clamped from all ones
        reconfigure(12'd1, 12'd0, 12'd3, 12'hFFF, grew);
        for (int k = 0; k < 60; k++) queue_pixel(8'($urandom_range(255)), k == 0);
        // Wider line over four rows
        reconfigure(12'd1, 12'd0, 12'd100, 12'd4, grew);
        for (int k = 0; k < 400; k++) queue_pixel(8'($urandom_range(255)), k == 0);

        // Geometry shrunk in the middle of a frame, no frame start
        reconfigure(12'd2, 12'd1, 12'd10, 12'd8, grew);
        for (int k = 0; k < 45; k++) queue_pixel(8'($urandom_range(255)), k == 0);
        reconfigure(12'd2, 12'd1, 12'd4, 12'd8, grew);
        for (int k = 0; k < 30; k++) queue_pixel(8'($urandom_range(255)), 1'b0);
        reconfigure(12'd1, 12'd1, 12'd4, 12'd3, grew);
        for (int k = 0; k < 20; k++) queue_pixel(8'($urandom_range(255)), 1'b0);

        // Random frames under each flow-control profile
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            for (int sg = 0; sg < 4; sg++) begin
                pat = 12'($urandom_range(4095));
                swp = 12'($urandom_range(4095));
                wd  = ($urandom_range(9) == 0) ? 12'($urandom_range(2))
                                               : 12'($urandom_range(14, 3));
                ht  = ($urandom_range(9) == 0) ? 12'($urandom_range(2))
                                               : 12'($urandom_range(9, 3));
                reconfigure(pat, swp, wd, ht, grew);
                // a wider line must start a new frame so no stale entry is read
                queue_stream(70, grew || $urandom_range(1), wd, ht);
                if (ph == 3 && sg == 0) begin
                    // stop feeding until every RGB transaction is out
                    while (raw_pending.size() > 35) @(posedge i_clk);
                    feed_hold <= 1'b1;
                    do @(posedge i_clk); while (s_axis_tvalid || !nothing_owed);
                    feed_hold <= 1'b0;
                end
            end
        end

        drain();
        if (err_count == 0 && rgb_expected.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
